// ----- rtl/core/sfl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the serial flash loader command engine.
// Holds request/reply payload structs, the controller/datapath command and status
// structs, register indexes and reset values. Depends on nothing.
package sfl_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TIMEOUT_W  = 20;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GO_CODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE    = 3'd5;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] RST_HEAD_TIMEOUT = 20'd655350;
    localparam logic [1:0]           RST_VERIFY_MODE  = 2'd2;
    localparam logic [7:0]           RST_HEAD_CODE    = 8'd127;
    localparam logic [7:0]           RST_GO_CODE      = 8'd1;
    localparam logic [7:0]           RST_WRITE_CODE   = 8'd2;
    localparam logic [7:0]           RST_READ_CODE    = 8'd3;

    // Verify modes
    localparam logic [1:0] VERIFY_NONE = 2'd0;

    // Reply codes
    typedef enum logic [3:0] {
        RK_HEAD_OK   = 4'd0,
        RK_XFER_OK   = 4'd1,
        RK_XFER_ERR  = 4'd2,
        RK_FLASH_OK  = 4'd3,
        RK_FLASH_ERR = 4'd4,
        RK_OK        = 4'd5,
        RK_UNKNOWN   = 4'd6,
        RK_READ_DATA = 4'd7,
        RK_GO_APP    = 4'd8
    } reply_kind_t;

    // One request: a received byte or a timer tick
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } sfl_in_t;

    // One reply
    typedef struct packed {
        reply_kind_t reply_kind;
        logic [7:0]  reply_data;
        logic        last_reply;
    } sfl_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic        timeout_inc;
        logic        load_index;
        logic        take_data;
        logic        copy_start;
        logic        copy_step;
        logic        rb_start;
        logic        rb_step;
        logic        read_issue;
        logic        emit;
        reply_kind_t emit_kind;
        logic        emit_last;
    } sfl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tick;
        logic is_head;
        logic is_go;
        logic is_write;
        logic is_read;
        logic timeout_hit;
        logic data_last;
        logic check_match;
        logic block_ok;
        logic mode_zero;
        logic mode_rb;
        logic cnt_last;
        logic rb_ok;
    } sfl_status_t;

endpackage

// ----- rtl/core/sfl_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the serial flash loader: session mode, command phase and the
// sequencer for block copy, readback and store reads.
// Depends on sfl_pkg; drives the datapath only through sfl_cmd_t.
module sfl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sfl_pkg::sfl_status_t status,
    output logic                 busy,
    output sfl_pkg::sfl_cmd_t    cmd
);
    import sfl_pkg::*;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'b001,
        MODE_CMD  = 3'b010,
        MODE_DONE = 3'b100
    } mode_t;

    typedef enum logic [4:0] {
        PH_CMD    = 5'b00001,
        PH_INDEX  = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_OFFSET = 5'b01000,
        PH_CHECK  = 5'b10000
    } phase_t;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_READ    = 7'b0000010,
        S_COPY    = 7'b0000100,
        S_CWAIT   = 7'b0001000,
        S_RBACK   = 7'b0010000,
        S_RWAIT   = 7'b0100000,
        S_VERDICT = 7'b1000000
    } state_t;

    mode_t  mode_reg, mode_next;
    phase_t phase_reg, phase_next;
    state_t state_reg, state_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Hold session, phase and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_WAIT;
            phase_reg <= PH_CMD;
            state_reg <= S_IDLE;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            state_reg <= state_next;
        end
    end

    // Decode the request and step the sequencer
    always_comb
    begin
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = RK_HEAD_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_reg)
                        MODE_WAIT:
                        begin
                            if (status.tick)
                            begin
                                cmd.timeout_inc = 1'b1;
                                if (status.timeout_hit)
                                begin
                                    mode_next     = MODE_DONE;
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = RK_GO_APP;
                                    cmd.emit_last = 1'b1;
                                end
                            end
                            else if (status.is_head)
                            begin
                                mode_next     = MODE_CMD;
                                phase_next    = PH_CMD;
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = RK_HEAD_OK;
                                cmd.emit_last = 1'b1;
                            end
                        end
                        MODE_CMD:
                        begin
                            if (!status.tick)
                            begin
                                unique case (phase_reg)
                                    PH_CMD:
                                    begin
                                        if (status.is_go)
                                        begin
                                            mode_next     = MODE_DONE;
                                            cmd.emit      = 1'b1;
                                            cmd.emit_kind = RK_GO_APP;
                                            cmd.emit_last = 1'b1;
                                        end
                                        else if (status.is_write)
                                        begin
                                            phase_next = PH_INDEX;
                                        end
                                        else if (status.is_read)
                                        begin
                                            phase_next = PH_OFFSET;
                                        end
                                        else
                                        begin
                                            cmd.emit      = 1'b1;
                                            cmd.emit_kind = RK_UNKNOWN;
                                            cmd.emit_last = 1'b1;
                                        end
                                    end
                                    PH_INDEX:
                                    begin
                                        cmd.load_index = 1'b1;
                                        phase_next     = PH_DATA;
                                    end
                                    PH_DATA:
                                    begin
                                        cmd.take_data = 1'b1;
                                        if (status.data_last)
                                        begin
                                            if (status.mode_zero)
                                            begin
                                                // No check byte: answer now, copy after
                                                phase_next    = PH_CMD;
                                                cmd.emit      = 1'b1;
                                                cmd.emit_kind = RK_OK;
                                                cmd.emit_last = 1'b1;
                                                if (status.block_ok)
                                                begin
                                                    cmd.copy_start = 1'b1;
                                                    state_next     = S_COPY;
                                                end
                                            end
                                            else
                                            begin
                                                phase_next = PH_CHECK;
                                            end
                                        end
                                    end
                                    PH_CHECK:
                                    begin
                                        phase_next    = PH_CMD;
                                        cmd.emit      = 1'b1;
                                        cmd.emit_last = 1'b1;
                                        if (!status.check_match)
                                        begin
                                            cmd.emit_kind = RK_XFER_ERR;
                                        end
                                        else
                                        begin
                                            cmd.emit_kind = RK_XFER_OK;
                                            // Readback follows with a second reply
                                            if (status.mode_rb)
                                            begin
                                                cmd.emit_last = 1'b0;
                                                state_next    = S_VERDICT;
                                            end
                                            if (status.block_ok)
                                            begin
                                                cmd.copy_start = 1'b1;
                                                state_next     = S_COPY;
                                            end
                                        end
                                    end
                                    PH_OFFSET:
                                    begin
                                        phase_next     = PH_CMD;
                                        cmd.read_issue = 1'b1;
                                        state_next     = S_READ;
                                    end
                                    default:
                                    begin
                                        phase_next = PH_CMD;
                                    end
                                endcase
                            end
                        end
                        MODE_DONE:
                        begin
                            // Session over: drop everything
                        end
                        default:
                        begin
                            mode_next = MODE_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = RK_READ_DATA;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_CWAIT;
                end
            end
            S_CWAIT:
            begin
                if (status.mode_rb)
                begin
                    cmd.rb_start = 1'b1;
                    state_next   = S_RBACK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RBACK:
            begin
                cmd.rb_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_RWAIT;
                end
            end
            S_RWAIT:
            begin
                state_next = S_VERDICT;
            end
            S_VERDICT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = status.rb_ok ? RK_FLASH_OK : RK_FLASH_ERR;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DONE) |=> (mode_reg == MODE_DONE))
        else $error("session left the ended mode");

    a_busy_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (mode_reg == MODE_CMD))
        else $error("sequencer busy outside command mode");

    a_partial_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !cmd.emit_last) |=> (state_reg == S_COPY || state_reg == S_VERDICT))
        else $error("non-final reply not followed by readback");
`endif

endmodule

// ----- rtl/core/sfl_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the serial flash loader: configuration registers, timeout counter,
// block buffer, byte store with per-block written flags, and the reply register.
// Depends on sfl_pkg; controlled by sfl_ctrl through sfl_cmd_t / sfl_status_t.
module sfl_datapath #(
    parameter int BLOCK_SIZE   = 64,
    parameter int STORE_BLOCKS = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sfl_pkg::sfl_in_t                 request,
    input  logic                             cfg_we,
    input  logic [sfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  sfl_pkg::sfl_cmd_t                cmd,
    output sfl_pkg::sfl_status_t             status,
    output logic                             reply_valid,
    output sfl_pkg::sfl_out_t                reply
);
    import sfl_pkg::*;

    localparam int STORE_BYTES = BLOCK_SIZE * STORE_BLOCKS;
    localparam int SA_W        = $clog2(STORE_BYTES);
    localparam int BA_W        = $clog2(BLOCK_SIZE);
    localparam int CNT_W       = $clog2(BLOCK_SIZE + 1);
    localparam int BI_W        = (STORE_BLOCKS > 1) ? $clog2(STORE_BLOCKS) : 1;
    // Offset to block number: exact reciprocal for any 8-bit offset
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;

    // Configuration registers
    logic [TIMEOUT_W-1:0] cfg_timeout_reg;
    logic [1:0]           cfg_verify_reg;
    logic [7:0]           cfg_head_reg;
    logic [7:0]           cfg_go_reg;
    logic [7:0]           cfg_write_reg;
    logic [7:0]           cfg_read_reg;

    // Session state
    logic [TIMEOUT_W-1:0] timeout_cnt_reg;
    logic [TIMEOUT_W-1:0] timeout_cnt_next;
    logic [TIMEOUT_W-1:0] timeout_limit;
    logic [7:0]           index_reg;
    logic [SA_W-1:0]      base_reg;
    logic [CNT_W-1:0]     byte_cnt_reg;
    logic [CNT_W-1:0]     byte_cnt_next;
    logic [7:0]           sum_reg;

    // Copy / readback sequencing
    logic [BA_W-1:0]      xfer_cnt_reg;
    logic                 wr_pend_reg;
    logic [SA_W-1:0]      wr_addr_reg;
    logic [7:0]           buf_rdata_reg;
    logic                 rd_pend_reg;
    logic [SA_W-1:0]      st_rd_addr;
    logic [7:0]           store_rdata_reg;
    logic [7:0]           rb_sum_reg;
    logic [STORE_BLOCKS-1:0] blk_valid_reg;

    // Store read for the read command
    logic [7:0]           off_reg;
    logic [31:0]          rd_prod;
    logic [BI_W-1:0]      rd_blk;
    logic                 rd_in_range;
    logic                 rd_hit;
    logic [7:0]           read_val;

    logic                 reply_valid_reg;
    sfl_out_t             reply_reg;

    logic [7:0]           buf_mem   [BLOCK_SIZE];
    logic [7:0]           store_mem [STORE_BYTES];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_timeout_reg <= RST_HEAD_TIMEOUT;
            cfg_verify_reg  <= RST_VERIFY_MODE;
            cfg_head_reg    <= RST_HEAD_CODE;
            cfg_go_reg      <= RST_GO_CODE;
            cfg_write_reg   <= RST_WRITE_CODE;
            cfg_read_reg    <= RST_READ_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAD_TIMEOUT: cfg_timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_VERIFY_MODE:  cfg_verify_reg  <= cfg_data[1:0];
                CFG_HEAD_CODE:    cfg_head_reg    <= cfg_data[7:0];
                CFG_GO_CODE:      cfg_go_reg      <= cfg_data[7:0];
                CFG_WRITE_CODE:   cfg_write_reg   <= cfg_data[7:0];
                CFG_READ_CODE:    cfg_read_reg    <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Compare the request against codes and counters
    always_comb
    begin
        timeout_cnt_next = timeout_cnt_reg + TIMEOUT_W'(1);
        timeout_limit    = (cfg_timeout_reg == '0) ? TIMEOUT_W'(1) : cfg_timeout_reg;
        byte_cnt_next    = byte_cnt_reg + CNT_W'(1);

        status.tick        = request.action;
        status.is_head     = (request.rx_byte == cfg_head_reg);
        status.is_go       = (request.rx_byte == cfg_go_reg);
        status.is_write    = (request.rx_byte == cfg_write_reg);
        status.is_read     = (request.rx_byte == cfg_read_reg);
        status.timeout_hit = (timeout_cnt_next >= timeout_limit);
        status.data_last   = (byte_cnt_next == CNT_W'(BLOCK_SIZE));
        status.check_match = (request.rx_byte == sum_reg);
        status.block_ok    = ({24'd0, index_reg} < 32'(STORE_BLOCKS));
        status.mode_zero   = (cfg_verify_reg == VERIFY_NONE);
        // Modes 2 and 3 both read the block back
        status.mode_rb     = cfg_verify_reg[1];
        status.cnt_last    = (xfer_cnt_reg == BA_W'(BLOCK_SIZE - 1));
        status.rb_ok       = status.block_ok && (rb_sum_reg == 8'd0);
    end

    // Advance session counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_cnt_reg <= '0;
            index_reg       <= '0;
            byte_cnt_reg    <= '0;
            sum_reg         <= '0;
            xfer_cnt_reg    <= '0;
            wr_pend_reg     <= 1'b0;
            rd_pend_reg     <= 1'b0;
            blk_valid_reg   <= '0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.timeout_inc)
            begin
                timeout_cnt_reg <= timeout_cnt_next;
            end
            if (cmd.load_index)
            begin
                index_reg    <= request.rx_byte;
                byte_cnt_reg <= '0;
                sum_reg      <= '0;
            end
            else if (cmd.take_data)
            begin
                byte_cnt_reg <= byte_cnt_next;
                sum_reg      <= sum_reg + request.rx_byte;
            end
            if (cmd.copy_start || cmd.rb_start)
            begin
                xfer_cnt_reg <= '0;
            end
            else if (cmd.copy_step || cmd.rb_step)
            begin
                xfer_cnt_reg <= xfer_cnt_reg + BA_W'(1);
            end
            if (cmd.copy_start)
            begin
                blk_valid_reg[index_reg[BI_W-1:0]] <= 1'b1;
            end
            wr_pend_reg     <= cmd.copy_step;
            rd_pend_reg     <= cmd.rb_step;
            reply_valid_reg <= cmd.emit;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_index)
        begin
            base_reg <= SA_W'(32'(request.rx_byte) * 32'(BLOCK_SIZE));
        end
        if (cmd.read_issue)
        begin
            off_reg <= request.rx_byte;
        end
        if (cmd.copy_step)
        begin
            wr_addr_reg <= base_reg + SA_W'(xfer_cnt_reg);
        end
        if (cmd.rb_start)
        begin
            rb_sum_reg <= sum_reg;
        end
        else if (rd_pend_reg)
        begin
            rb_sum_reg <= rb_sum_reg - store_rdata_reg;
        end
        if (cmd.emit)
        begin
            reply_reg.reply_kind <= cmd.emit_kind;
            reply_reg.reply_data <= (cmd.emit_kind == RK_READ_DATA) ? read_val : 8'd0;
            reply_reg.last_reply <= cmd.emit_last;
        end
    end

    // Block buffer: fill from data bytes, read one byte a cycle for the copy
    always_ff @(posedge clk)
    begin
        if (cmd.take_data)
        begin
            buf_mem[byte_cnt_reg[BA_W-1:0]] <= request.rx_byte;
        end
        buf_rdata_reg <= buf_mem[xfer_cnt_reg];
    end

    // Byte store: one write port for the copy, one registered read port
    assign st_rd_addr = cmd.read_issue ? SA_W'(request.rx_byte)
                                       : base_reg + SA_W'(xfer_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            store_mem[wr_addr_reg] <= buf_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        store_rdata_reg <= store_mem[st_rd_addr];
    end

    // Mask reads of blocks never written and offsets past the store
    always_comb
    begin
        rd_prod     = 32'(off_reg) * 32'(RECIP);
        rd_blk      = rd_prod[RECIP_SHIFT +: BI_W];
        rd_in_range = ({24'd0, off_reg} < 32'(STORE_BYTES));
        rd_hit      = rd_in_range && blk_valid_reg[rd_blk];
        read_val    = rd_hit ? store_rdata_reg : 8'd0;
    end

    assign reply_valid = reply_valid_reg;
    assign reply       = reply_reg;

`ifndef NO_ASSERTIONS
    a_copy_rb_apart: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> !rd_pend_reg)
        else $error("store write and readback overlap");

    a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_start |-> status.block_ok)
        else $error("copy started for a block outside the store");

    a_data_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid_reg && (reply_reg.reply_kind != RK_READ_DATA))
            |-> (reply_reg.reply_data == 8'd0))
        else $error("reply data set on a non-read reply");
`endif

endmodule

// ----- rtl/core/serial_flash_loader_protocol_top.sv -----
`timescale 1ns / 1ps
// Top level of the serial flash loader command engine.
// Joins sfl_ctrl and sfl_datapath; uses sfl_pkg types on its ports.
//
// Usage:
//   Requests enter on request (a received byte or a timer tick) when start is
//   high and busy is low. Replies leave on reply, one per cycle, marked by
//   reply_valid for exactly one cycle; the receiver must take them as they come.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// Sequencing:
//   Most requests finish at acceptance; a reply shows the cycle after acceptance and
//   busy stays low. A read command's final byte raises busy while the registered
//   store read finishes and its reply is issued. The final data or check byte of
//   a block write inside the store, once any check byte matches, starts a copy
//   through the single store write port; with readback on, the block is read back
//   via the store read port before the flash reply. busy is high during that work.
// Reset:
//   Registers return to their reset values, the session waits for the head
//   byte, and every store block reads as zero until written.
module serial_flash_loader_protocol_top #(
    parameter int BLOCK_SIZE   = 64,
    parameter int STORE_BLOCKS = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfl_pkg::sfl_in_t               request,
    output logic                           reply_valid,
    output sfl_pkg::sfl_out_t              reply,
    input  logic                           cfg_we,
    input  logic [sfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfl_pkg::*;

    sfl_cmd_t    cmd;
    sfl_status_t status;

    // Sequence requests
    sfl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Store, buffer and reply register
    sfl_datapath #(
        .BLOCK_SIZE   (BLOCK_SIZE),
        .STORE_BLOCKS (STORE_BLOCKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .reply_valid (reply_valid),
        .reply       (reply)
    );

endmodule
